@@ src/spgu_pkg.sv @@
package spgu_pkg;

    localparam int TBL_LAST = 24;
    localparam int LUT_W = 17;
    localparam logic [LUT_W-1:0] Q16_ONE = 17'h10000;
    localparam logic FUNC_FWD = 1'b0;
    localparam logic FUNC_BWD = 1'b1;

    typedef logic [LUT_W-1:0] lut_t;
    typedef logic [4:0] lut_idx_t;

    function automatic lut_t log_lut(input lut_idx_t idx);
        lut_t v;
        case (idx)
            5'd0:    v = 17'd45426;
            5'd1:    v = 17'd31069;
            5'd2:    v = 17'd20530;
            5'd3:    v = 17'd13200;
            5'd4:    v = 17'd8318;
            5'd5:    v = 17'd5170;
            5'd6:    v = 17'd3184;
            5'd7:    v = 17'd1950;
            5'd8:    v = 17'd1189;
            5'd9:    v = 17'd724;
            5'd10:   v = 17'd440;
            5'd11:   v = 17'd267;
            5'd12:   v = 17'd162;
            5'd13:   v = 17'd98;
            5'd14:   v = 17'd60;
            5'd15:   v = 17'd36;
            5'd16:   v = 17'd22;
            5'd17:   v = 17'd13;
            5'd18:   v = 17'd8;
            5'd19:   v = 17'd5;
            5'd20:   v = 17'd3;
            5'd21:   v = 17'd2;
            5'd22:   v = 17'd1;
            5'd23:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    function automatic lut_t sig_lut(input lut_idx_t idx);
        lut_t v;
        case (idx)
            5'd0:    v = 17'd32768;
            5'd1:    v = 17'd40793;
            5'd2:    v = 17'd47910;
            5'd3:    v = 17'd53581;
            5'd4:    v = 17'd57724;
            5'd5:    v = 17'd60564;
            5'd6:    v = 17'd62428;
            5'd7:    v = 17'd63615;
            5'd8:    v = 17'd64357;
            5'd9:    v = 17'd64816;
            5'd10:   v = 17'd65097;
            5'd11:   v = 17'd65269;
            5'd12:   v = 17'd65374;
            5'd13:   v = 17'd65438;
            5'd14:   v = 17'd65476;
            5'd15:   v = 17'd65500;
            5'd16:   v = 17'd65514;
            5'd17:   v = 17'd65523;
            5'd18:   v = 17'd65528;
            5'd19:   v = 17'd65531;
            5'd20:   v = 17'd65533;
            5'd21:   v = 17'd65534;
            5'd22:   v = 17'd65535;
            5'd23:   v = 17'd65535;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

endpackage

@@ src/softplus_and_gradient_unit_top.sv @@
// Elementwise softplus (func = 0) and sigmoid-gradient (func = 1) unit on signed fixed
// point values with FRAC_BITS fraction bits. An element is taken on every cycle that start
// is high; busy stays low, so elements may stream back to back with no gaps. Each result
// appears on result_value exactly six cycles after its start, marked by a one-cycle done
// pulse, and must be captured then: there is no way to hold results off. Latency is set by
// the six register stages: input/abs, table read, interpolation multiply, interpolation
// add, output scaling multiply or add, and rounding/saturation.
module softplus_and_gradient_unit_top #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  func,
    input  logic [DATA_WIDTH-1:0] x_value,
    input  logic [DATA_WIDTH-1:0] grad_in,
    output logic [DATA_WIDTH-1:0] result_value,
    output logic                  done
);
    import spgu_pkg::*;

    localparam int DW  = DATA_WIDTH;
    localparam int LAT = 6;
    localparam int EW  = DW + FRAC_BITS;
    localparam int FW  = FRAC_BITS - 1 + 16;
    localparam int GW  = (FRAC_BITS > 16) ? FRAC_BITS + 1 : LUT_W;
    localparam int SW  = ((DW > GW) ? DW : GW) + 1;
    localparam int PW  = DW + LUT_W;
    localparam int QW  = DW + 2;
    localparam logic [SW-1:0] S_HI = SW'((64'(1) << (DW - 1)) - 64'(1));
    localparam logic [QW-1:0] P_HI = QW'((64'(1) << (DW - 1)) - 64'(1));
    localparam logic [QW-1:0] P_LO = QW'(64'(1) << (DW - 1));
    localparam logic [DW-1:0] R_HI = DW'((64'(1) << (DW - 1)) - 64'(1));
    localparam logic [DW-1:0] R_LO = DW'(64'(1) << (DW - 1));

    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;

    logic          func_s1_reg, func_s2_reg, func_s3_reg, func_s4_reg, func_s5_reg;
    logic          func_s6_reg;
    logic          xneg_s1_reg, xneg_s2_reg, xneg_s3_reg;
    logic          dyneg_s1_reg, dyneg_s2_reg, dyneg_s3_reg, dyneg_s4_reg, dyneg_s5_reg;
    logic          dyneg_s6_reg;
    logic [DW-1:0] t_s1_reg;
    logic [DW-2:0] xpos_s1_reg, xpos_s2_reg, xpos_s3_reg, xpos_s4_reg;
    logic [DW-1:0] dymag_s1_reg, dymag_s2_reg, dymag_s3_reg, dymag_s4_reg;

    logic [DW-1:0] t_next, dymag_next;
    logic [DW-2:0] xpos_next;

    logic [EW-1:0] t_ext, idx_full;
    logic [FW-1:0] fsh;
    lut_idx_t      idx;
    lut_t          a_val, b_val, diff_next;
    logic          beyond_next;

    lut_t          a_s2_reg, a_s3_reg;
    lut_t          diff_s2_reg;
    logic [15:0]   f16_s2_reg;
    logic          down_s2_reg, down_s3_reg;
    logic          beyond_s2_reg, beyond_s3_reg;
    logic [32:0]   prod_s3_reg;

    lut_t          dv, v_val, lut_next;
    lut_t          lut_s4_reg;

    logic [GW-1:0] g_val;
    logic [SW-1:0] sum_val;
    logic [DW-1:0] fwd_next;
    logic [DW-1:0] fwd_s5_reg;
    logic [PW-1:0] bprod_s5_reg;

    logic [PW:0]   rnd;
    logic [QW-1:0] p_val;
    logic [DW-1:0] bwd_res;
    logic [DW-1:0] result_value_reg;
    logic [DW-1:0] result_value_next;

    assign busy = 1'b0;

    assign vld_next = {vld_reg[LAT-2:0], start & ~busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // stage 1: capture and take magnitudes
    always_comb
    begin
        t_next     = x_value[DW-1] ? (~x_value + 1'b1) : x_value;
        dymag_next = grad_in[DW-1] ? (~grad_in + 1'b1) : grad_in;
        xpos_next  = x_value[DW-1] ? '0 : x_value[DW-2:0];
    end

    always_ff @(posedge clk)
    begin
        func_s1_reg  <= func;
        xneg_s1_reg  <= x_value[DW-1];
        dyneg_s1_reg <= grad_in[DW-1];
        t_s1_reg     <= t_next;
        xpos_s1_reg  <= xpos_next;
        dymag_s1_reg <= dymag_next;
    end

    // stage 2: segment select and table read
    always_comb
    begin
        t_ext       = EW'(t_s1_reg);
        idx_full    = t_ext >> (FRAC_BITS - 1);
        beyond_next = (idx_full >= EW'(TBL_LAST));
        idx         = idx_full[4:0];
        fsh         = {t_ext[FRAC_BITS-2:0], 16'b0} >> (FRAC_BITS - 1);
        if (func_s1_reg == FUNC_BWD)
        begin
            a_val = sig_lut(idx);
            b_val = sig_lut(idx + 5'd1);
        end
        else
        begin
            a_val = log_lut(idx);
            b_val = log_lut(idx + 5'd1);
        end
        diff_next = (a_val >= b_val) ? (a_val - b_val) : (b_val - a_val);
    end

    always_ff @(posedge clk)
    begin
        func_s2_reg   <= func_s1_reg;
        xneg_s2_reg   <= xneg_s1_reg;
        dyneg_s2_reg  <= dyneg_s1_reg;
        xpos_s2_reg   <= xpos_s1_reg;
        dymag_s2_reg  <= dymag_s1_reg;
        a_s2_reg      <= a_val;
        diff_s2_reg   <= diff_next;
        down_s2_reg   <= (a_val >= b_val);
        beyond_s2_reg <= beyond_next;
        f16_s2_reg    <= fsh[15:0];
    end

    // stage 3: interpolation product
    always_ff @(posedge clk)
    begin
        func_s3_reg   <= func_s2_reg;
        xneg_s3_reg   <= xneg_s2_reg;
        dyneg_s3_reg  <= dyneg_s2_reg;
        xpos_s3_reg   <= xpos_s2_reg;
        dymag_s3_reg  <= dymag_s2_reg;
        a_s3_reg      <= a_s2_reg;
        down_s3_reg   <= down_s2_reg;
        beyond_s3_reg <= beyond_s2_reg;
        prod_s3_reg   <= 33'(diff_s2_reg) * 33'(f16_s2_reg);
    end

    // stage 4: interpolated value, mirror sigmoid for negative x
    always_comb
    begin
        dv = prod_s3_reg[32:16];
        if (beyond_s3_reg)
        begin
            v_val = (func_s3_reg == FUNC_BWD) ? Q16_ONE : '0;
        end
        else if (down_s3_reg)
        begin
            v_val = a_s3_reg - dv;
        end
        else
        begin
            v_val = a_s3_reg + dv;
        end
        lut_next = ((func_s3_reg == FUNC_BWD) && xneg_s3_reg) ? (Q16_ONE - v_val) : v_val;
    end

    always_ff @(posedge clk)
    begin
        func_s4_reg  <= func_s3_reg;
        dyneg_s4_reg <= dyneg_s3_reg;
        xpos_s4_reg  <= xpos_s3_reg;
        dymag_s4_reg <= dymag_s3_reg;
        lut_s4_reg   <= lut_next;
    end

    // stage 5: forward sum or backward scaling product
    if (FRAC_BITS < 16)
    begin : g_round
        localparam int SH = 16 - FRAC_BITS;
        logic [LUT_W:0] g_sum;
        assign g_sum = {1'b0, lut_s4_reg} + (LUT_W + 1)'(64'(1) << (SH - 1));
        assign g_val = GW'(g_sum >> SH);
    end
    else
    begin : g_widen
        assign g_val = GW'(lut_s4_reg) << (FRAC_BITS - 16);
    end

    always_comb
    begin
        sum_val  = SW'(xpos_s4_reg) + SW'(g_val);
        fwd_next = (sum_val > S_HI) ? R_HI : sum_val[DW-1:0];
    end

    always_ff @(posedge clk)
    begin
        func_s5_reg  <= func_s4_reg;
        dyneg_s5_reg <= dyneg_s4_reg;
        fwd_s5_reg   <= fwd_next;
        bprod_s5_reg <= PW'(dymag_s4_reg) * PW'(lut_s4_reg);
    end

    // stage 6: round, restore sign, saturate
    always_comb
    begin
        rnd   = (PW + 1)'(bprod_s5_reg) + (PW + 1)'(32768);
        p_val = rnd[PW:16];
        if (dyneg_s5_reg)
        begin
            bwd_res = (p_val > P_LO) ? R_LO : (~p_val[DW-1:0] + 1'b1);
        end
        else
        begin
            bwd_res = (p_val > P_HI) ? R_HI : p_val[DW-1:0];
        end
        result_value_next = (func_s5_reg == FUNC_BWD) ? bwd_res : fwd_s5_reg;
    end

    always_ff @(posedge clk)
    begin
        func_s6_reg      <= func_s5_reg;
        dyneg_s6_reg     <= dyneg_s5_reg;
        result_value_reg <= result_value_next;
    end

    assign result_value = result_value_reg;
    assign done         = vld_reg[LAT-1];

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##6 done)
        else $error("transfer did not produce a result after the pipeline latency");

    a_fwd_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        (done && func_s6_reg == FUNC_FWD) |-> !result_value[DW-1])
        else $error("softplus result is negative");

    a_bwd_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (done && func_s6_reg == FUNC_BWD && dyneg_s6_reg)
            |-> (result_value[DW-1] || result_value == '0))
        else $error("gradient sign does not follow upstream gradient");

endmodule

@@ tb/softplus_and_gradient_unit_top_tb.sv @@
module softplus_and_gradient_unit_top_tb;

    import spgu_pkg::*;

    localparam int DATA_WIDTH     = 16;
    localparam int FRAC_BITS      = 8;
    localparam int STEP_SHIFT     = FRAC_BITS - 1;
    localparam int PIPE_DEPTH     = 6;
    localparam int RANDOM_ITEMS   = 625;
    localparam int WATCHDOG_LIMIT = 500;
    localparam longint CLIP_LIMIT = 50 * (longint'(1) << FRAC_BITS);

    localparam int LN_TAIL_Q16 [0:24] = '{
        45426, 31069, 20530, 13200, 8318, 5170, 3184, 1950, 1189,
        724, 440, 267, 162, 98, 60, 36, 22, 13, 8, 5, 3, 2, 1, 1, 0
    };

    localparam int LOGISTIC_Q16 [0:24] = '{
        32768, 40793, 47910, 53581, 57724, 60564, 62428, 63615, 64357,
        64816, 65097, 65269, 65374, 65438, 65476, 65500, 65514, 65523,
        65528, 65531, 65533, 65534, 65535, 65535, 65536
    };

    typedef struct {
        logic                  fn;
        logic [DATA_WIDTH-1:0] x;
        logic [DATA_WIDTH-1:0] dy;
        bit                    known;
        logic [DATA_WIDTH-1:0] want;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 23;

    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{FUNC_FWD, 16'h0000, 16'h0000, 1'b1, 16'h00B1},
        '{FUNC_FWD, 16'h7FFF, 16'h1234, 1'b1, 16'h7FFF},
        '{FUNC_FWD, 16'h8000, 16'hFFFF, 1'b1, 16'h0000},
        '{FUNC_BWD, 16'h0000, 16'h0100, 1'b1, 16'h0080},
        '{FUNC_BWD, 16'h0000, 16'h0000, 1'b1, 16'h0000},
        '{FUNC_BWD, 16'h7FFF, 16'h8000, 1'b1, 16'h8000},
        '{FUNC_BWD, 16'h7FFF, 16'h7FFF, 1'b1, 16'h7FFF},
        '{FUNC_BWD, 16'h8000, 16'h7FFF, 1'b1, 16'h0000},
        '{FUNC_BWD, 16'h0000, 16'h0001, 1'b1, 16'h0001},
        '{FUNC_BWD, 16'h0000, 16'hFFFF, 1'b1, 16'hFFFF},
        '{FUNC_FWD, 16'h0C00, 16'h0000, 1'b0, 16'h0000},
        '{FUNC_FWD, 16'h0BFF, 16'h0000, 1'b0, 16'h0000},
        '{FUNC_FWD, 16'hF400, 16'h0000, 1'b0, 16'h0000},
        '{FUNC_FWD, 16'hF401, 16'h0000, 1'b0, 16'h0000},
        '{FUNC_BWD, 16'h3200, 16'h4000, 1'b0, 16'h0000},
        '{FUNC_BWD, 16'h3201, 16'hC000, 1'b0, 16'h0000},
        '{FUNC_BWD, 16'h0080, 16'h7FFF, 1'b0, 16'h0000},
        '{FUNC_BWD, 16'hFF80, 16'h8000, 1'b0, 16'h0000},
        '{FUNC_FWD, 16'h0001, 16'hAAAA, 1'b0, 16'h0000},
        '{FUNC_FWD, 16'hFFFF, 16'h5555, 1'b0, 16'h0000},
        '{FUNC_BWD, 16'h0BFF, 16'h0100, 1'b0, 16'h0000},
        '{FUNC_BWD, 16'hF400, 16'h0100, 1'b0, 16'h0000},
        '{FUNC_FWD, 16'h0040, 16'h0000, 1'b0, 16'h0000}
    };

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  start        = 1'b0;
    logic                  func         = FUNC_FWD;
    logic [DATA_WIDTH-1:0] x_value      = '0;
    logic [DATA_WIDTH-1:0] grad_in      = '0;
    logic                  busy;
    logic [DATA_WIDTH-1:0] result_value;
    logic                  done;

    logic [DATA_WIDTH-1:0] expected_results [$];
    int                    mismatch_count = 0;
    int                    checked_count  = 0;
    int                    forward_count  = 0;
    int                    backward_count = 0;
    int                    idle_cycles    = 0;

    softplus_and_gradient_unit_top #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .x_value      (x_value),
        .grad_in      (grad_in),
        .result_value (result_value),
        .done         (done)
    );

    always #10 clk = ~clk;

    function automatic longint interp_q16(bit use_logistic, longint t);
        longint idx;
        longint frac;
        longint f16;
        longint a;
        longint b;
        idx = t >>> STEP_SHIFT;
        if (idx >= TBL_LAST)
        begin
            return use_logistic ? longint'(Q16_ONE) : longint'(0);
        end
        frac = t & ((longint'(1) << STEP_SHIFT) - 1);
        f16  = (frac << 16) >>> STEP_SHIFT;
        a    = longint'(use_logistic ? LOGISTIC_Q16[5'(idx)] : LN_TAIL_Q16[5'(idx)]);
        b    = longint'(use_logistic ? LOGISTIC_Q16[5'(idx + 1)] : LN_TAIL_Q16[5'(idx + 1)]);
        if (a >= b)
        begin
            return a - (((a - b) * f16) >>> 16);
        end
        return a + (((b - a) * f16) >>> 16);
    endfunction

    function automatic logic [DATA_WIDTH-1:0] softplus_grad_predict(
        logic fn, logic signed [DATA_WIDTH-1:0] x, logic signed [DATA_WIDTH-1:0] dy);
        longint xv;
        longint dv;
        longint t;
        longint s;
        longint mag;
        longint p;
        longint r;
        longint hi;
        longint lo;
        xv = longint'(x);
        dv = longint'(dy);
        hi = (longint'(1) << (DATA_WIDTH - 1)) - 1;
        lo = -hi - 1;
        if (fn == FUNC_FWD)
        begin
            t = (xv < 0) ? -xv : xv;
            r = interp_q16(1'b0, t);
            r = (r + (longint'(1) << (16 - FRAC_BITS - 1))) >>> (16 - FRAC_BITS);
            r = r + ((xv > 0) ? xv : 0);
        end
        else
        begin
            if (xv > CLIP_LIMIT)
            begin
                xv = CLIP_LIMIT;
            end
            t = (xv < 0) ? -xv : xv;
            s = interp_q16(1'b1, t);
            if (xv < 0)
            begin
                s = longint'(Q16_ONE) - s;
            end
            mag = (dv < 0) ? -dv : dv;
            p   = (mag * s + 32768) >>> 16;
            r   = (dv < 0) ? -p : p;
        end
        if (r > hi)
        begin
            r = hi;
        end
        if (r < lo)
        begin
            r = lo;
        end
        return r[DATA_WIDTH-1:0];
    endfunction

    task automatic transfer_element(logic fn, logic [DATA_WIDTH-1:0] x,
                                    logic [DATA_WIDTH-1:0] dy, bit known,
                                    logic [DATA_WIDTH-1:0] want);
        start   <= 1'b1;
        func    <= fn;
        x_value <= x;
        grad_in <= dy;
        do
            @(posedge clk);
        while (busy);
        expected_results.push_back(known ? want : softplus_grad_predict(fn, x, dy));
        if (fn == FUNC_FWD)
        begin
            forward_count++;
        end
        else
        begin
            backward_count++;
        end
    endtask

    task automatic hold_idle(int cycles);
        if (cycles > 0)
        begin
            start   <= 1'b0;
            x_value <= DATA_WIDTH'($urandom);
            grad_in <= DATA_WIDTH'($urandom);
            func    <= 1'($urandom_range(0, 1));
            repeat (cycles) @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result_value: unexpected result %h with nothing pending", result_value);
                mismatch_count++;
            end
            else
            begin
                logic [DATA_WIDTH-1:0] want;
                want = expected_results.pop_front();
                checked_count++;
                if (result_value !== want)
                begin
                    $error("result_value: expected %h, actual %h", want, result_value);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin
        int                    burst_left;
        int                    sent;
        logic                  fn;
        logic [DATA_WIDTH-1:0] x;
        logic [DATA_WIDTH-1:0] dy;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            transfer_element(directed_rows[i].fn, directed_rows[i].x, directed_rows[i].dy,
                             directed_rows[i].known, directed_rows[i].want);
            hold_idle(($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0);
        end

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            burst_left = $urandom_range(1, 24);
            while (burst_left > 0 && sent < RANDOM_ITEMS)
            begin
                fn = 1'($urandom_range(0, 1));
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: x = DATA_WIDTH'($urandom_range(0, 6400) - 3200);
                    5:             x = DATA_WIDTH'(CLIP_LIMIT + $urandom_range(0, 20) - 10);
                    default:       x = DATA_WIDTH'($urandom);
                endcase
                if ($urandom_range(0, 3) == 0)
                begin
                    dy = DATA_WIDTH'($urandom_range(0, 1023) - 512);
                end
                else
                begin
                    dy = DATA_WIDTH'($urandom);
                end
                transfer_element(fn, x, dy, 1'b0, '0);
                burst_left--;
                sent++;
            end
            hold_idle(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9));
        end

        start <= 1'b0;
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (PIPE_DEPTH + 4) @(posedge clk);

        if (expected_results.size() != 0)
        begin
            $error("result_value: %0d results never arrived", expected_results.size());
            mismatch_count++;
        end

        $display("Streamed %0d softplus and %0d gradient elements in bursts with gaps,",
                 forward_count, backward_count);
        $display("%0d results compared, %0d mismatches.", checked_count, mismatch_count);
        if (mismatch_count == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
